>>> sv/timed_task_scheduler_assert.svh
// Assertion macros for the timed task scheduler
`ifndef TIMED_TASK_SCHEDULER_ASSERT_SVH
`define TIMED_TASK_SCHEDULER_ASSERT_SVH
// implication checked at every clock edge outside reset
`define TTS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tts check failed");
// implication checked on the following clock edge
`define TTS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tts check failed");
`endif

>>> sv/tts_pkg.sv
// Package: widths, command and status codes for the timed task scheduler
package tts_pkg;
    localparam int TimerSlots = 16;
    localparam int ReadyDepth = 16;
    localparam int TimeBits   = 32;
    localparam int SlotBits   = $clog2(TimerSlots);
    localparam int PosBits    = $clog2(ReadyDepth);
    localparam int CntBits    = $clog2(ReadyDepth + 1);

    typedef enum logic [2:0] {
        CMD_PUSH = 3'd0, CMD_ADD_PER = 3'd1, CMD_ADD_DLY = 3'd2, CMD_REMOVE = 3'd3,
        CMD_CLEAR = 3'd4, CMD_POP = 3'd5, CMD_REFRESH = 3'd6, CMD_NONE = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_BUSY = 2'd2, ST_OVF = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                cmd;
        logic [3:0]          tag;
        logic [31:0]         handle;
        logic [31:0]         interval;
        logic [TimeBits-1:0] now;
    } t_item;

    typedef struct packed {
        logic rd_valid;
        logic rd_ready;
    } t_qctl;
endpackage

>>> sv/tts_front.sv
// Front part: takes commands into a two-entry queue
module tts_front import tts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_item       i_item,
    input  logic        i_pop,
    output logic        o_full,
    output t_qctl       o_ctl,
    output t_item       o_item
);
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_ctl.rd_valid = (r_cnt != 2'd0);
    assign o_ctl.rd_ready = i_pop;
    assign o_item = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_start && !o_full) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_start && !o_full) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_start && !o_full} - {1'b0, i_pop};
        end
    end
endmodule

>>> sv/tts_back.sv
// Back part: timer table, ready queue and command sequencer
module tts_back import tts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qctl       i_ctl,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_idle,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_out_tag,
    output logic [31:0] o_out_handle,
    output logic [31:0] o_out_interval,
    output logic [4:0]  o_released_count
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_SHIFT = 4'b0100, S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_item  r_it;

    logic [TimerSlots-1:0] r_sv, r_sp;
    logic [31:0]           r_sh [TimerSlots];
    logic [31:0]           r_si [TimerSlots];
    logic [TimeBits-1:0]   r_sl [TimerSlots];
    logic [3:0]            r_qt [ReadyDepth];
    logic [31:0]           r_qh [ReadyDepth];
    logic [31:0]           r_qi [ReadyDepth];
    logic [CntBits-1:0]    r_cnt;

    logic [SlotBits:0]     r_idx;      // scan index, extra bit ends the pass
    logic                  r_pass;     // 0 periodic, 1 delayed
    logic [PosBits-1:0]    r_pos;
    logic [1:0]            r_st;
    logic [4:0]            r_rel;
    logic [3:0]            r_otag;
    logic [31:0]           r_oh, r_oi;

    logic [SlotBits-1:0]   w_s;
    logic [TimeBits-1:0]   w_el;
    logic                  w_due, w_full, w_slot_ok;
    logic [PosBits:0]      w_hit;
    logic [PosBits-1:0]    w_cp;

    function automatic logic [PosBits-1:0] w_cnt_pos(input logic [CntBits-1:0] c);
        return c[PosBits-1:0];
    endfunction

    assign w_s       = r_idx[SlotBits-1:0];
    assign w_el      = r_it.now - r_sl[w_s];
    assign w_due     = r_sv[w_s] && (r_sp[w_s] == !r_pass) && (w_el >= r_si[w_s]);
    assign w_full    = (r_cnt >= CntBits'(ReadyDepth));
    assign w_slot_ok = ({28'd0, r_it.tag} < 32'(TimerSlots));
    assign w_cp      = w_cnt_pos(r_cnt);

    always_comb begin
        w_hit = {1'b1, {PosBits{1'b0}}};
        for (int i = ReadyDepth - 1; i >= 0; i--) begin
            if (CntBits'(i) < r_cnt && r_qt[i] == r_it.tag) w_hit = (PosBits+1)'(i);
        end
    end

    assign o_pop  = (r_state == S_IDLE) && i_ctl.rd_valid;
    assign o_idle = (r_state == S_IDLE) && !i_ctl.rd_valid;
    assign o_done = (r_state == S_DONE);
    assign o_status = r_st;
    assign o_out_tag = r_otag;
    assign o_out_handle = r_oh;
    assign o_out_interval = r_oi;
    assign o_released_count = r_rel;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (o_pop) n_state = S_SCAN;
            S_SCAN: begin
                unique case (r_it.cmd)
                    CMD_REFRESH: if (r_pass && r_idx[SlotBits]) n_state = S_DONE;
                    CMD_REMOVE: n_state = w_hit[PosBits] ? S_DONE : S_SHIFT;
                    CMD_POP: n_state = (r_cnt == '0) ? S_DONE : S_SHIFT;
                    default: n_state = S_DONE;
                endcase
            end
            S_SHIFT: if ({1'b0, r_pos} + 1'b1 >= r_cnt) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sv    <= '0;
            r_sp    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_it   <= i_item;
                        r_idx  <= '0;
                        r_pass <= 1'b0;
                        r_st   <= ST_OK;
                        r_rel  <= '0;
                        r_otag <= i_item.tag;
                        r_oh   <= '0;
                        r_oi   <= '0;
                    end
                end
                S_SCAN: begin
                    case (r_it.cmd)
                        CMD_PUSH: begin
                            if (w_full) r_st <= ST_OVF;
                            else begin
                                r_qt[w_cp] <= r_it.tag;
                                r_qh[w_cp] <= r_it.handle;
                                r_qi[w_cp] <= '0;
                                r_cnt      <= r_cnt + 1'b1;
                            end
                        end
                        CMD_ADD_PER, CMD_ADD_DLY: begin
                            if (!w_slot_ok || r_sv[r_it.tag[SlotBits-1:0]]) r_st <= ST_BUSY;
                            else begin
                                r_sv[r_it.tag[SlotBits-1:0]] <= 1'b1;
                                r_sp[r_it.tag[SlotBits-1:0]] <= (r_it.cmd == CMD_ADD_PER);
                                r_sh[r_it.tag[SlotBits-1:0]] <= r_it.handle;
                                r_si[r_it.tag[SlotBits-1:0]] <= r_it.interval;
                                r_sl[r_it.tag[SlotBits-1:0]] <= r_it.now;
                                if (r_it.cmd == CMD_ADD_PER) begin
                                    if (w_full) r_st <= ST_OVF;
                                    else begin
                                        r_qt[w_cp] <= r_it.tag;
                                        r_qh[w_cp] <= r_it.handle;
                                        r_qi[w_cp] <= r_it.interval;
                                        r_cnt      <= r_cnt + 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (w_slot_ok) begin
                                r_sv[r_it.tag[SlotBits-1:0]] <= 1'b0;
                                r_sp[r_it.tag[SlotBits-1:0]] <= 1'b0;
                            end
                            r_pos <= w_hit[PosBits-1:0];
                        end
                        CMD_CLEAR: begin
                            r_sv  <= '0;
                            r_sp  <= '0;
                            r_cnt <= '0;
                        end
                        CMD_POP: begin
                            r_pos <= '0;
                            if (r_cnt == '0) begin
                                r_st <= ST_EMPTY;
                            end else begin
                                r_otag <= r_qt[0];
                                r_oh   <= r_qh[0];
                                r_oi   <= r_qi[0];
                            end
                        end
                        CMD_REFRESH: begin
                            if (r_idx[SlotBits]) begin
                                r_idx  <= '0;
                                r_pass <= 1'b1;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                                if (w_due) begin
                                    if (w_full) r_st <= ST_OVF;
                                    else begin
                                        r_qt[w_cp] <= 4'(w_s);
                                        r_qh[w_cp] <= r_sh[w_s];
                                        r_qi[w_cp] <= r_si[w_s];
                                        r_cnt      <= r_cnt + 1'b1;
                                        if (r_rel != 5'd31) r_rel <= r_rel + 1'b1;
                                    end
                                    if (!r_pass) r_sl[w_s] <= r_it.now;
                                    else begin
                                        r_sv[w_s] <= 1'b0;
                                        r_sp[w_s] <= 1'b0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                S_SHIFT: begin
                    if ({1'b0, r_pos} + 1'b1 < r_cnt) begin
                        r_qt[r_pos] <= r_qt[r_pos + 1'b1];
                        r_qh[r_pos] <= r_qh[r_pos + 1'b1];
                        r_qi[r_pos] <= r_qi[r_pos + 1'b1];
                        r_pos       <= r_pos + 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> sv/timed_task_scheduler.sv
// Top level of the timed task scheduler
// Commands enter a two-deep queue whenever busy is low; the back end runs one
// command at a time. Pop and remove shift the later ready entries down one
// place at a time, and refresh scans one timer slot per cycle in two passes,
// periodic then delayed. The result appears for one cycle with o_done high and
// cannot be held off, so it must be taken on that cycle.
`include "timed_task_scheduler_assert.svh"
module timed_task_scheduler import tts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_task_tag,
    input  logic [31:0] i_handle,
    input  logic [31:0] i_interval_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [3:0]  o_out_tag,
    output logic [31:0] o_out_handle,
    output logic [31:0] o_out_interval,
    output logic [4:0]  o_released_count
);
    t_item w_in, w_q;
    t_qctl w_ctl;
    logic  w_pop, w_idle;

    assign w_in = '{cmd: t_cmd'(i_cmd), tag: i_task_tag, handle: i_handle,
                    interval: i_interval_ms, now: TimeBits'(i_now_ms)};

    tts_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(w_in),
        .i_pop(w_pop), .o_full(busy), .o_ctl(w_ctl), .o_item(w_q)
    );

    tts_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_item(w_q),
        .o_pop(w_pop), .o_idle(w_idle), .o_done(o_done), .o_status(o_status),
        .o_out_tag(o_out_tag), .o_out_handle(o_out_handle),
        .o_out_interval(o_out_interval), .o_released_count(o_released_count)
    );

    `TTS_ASSERT_IMP(a_done_not_idle, i_clk, i_rst_n, o_done, !w_idle)
    `TTS_ASSERT_NXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `TTS_ASSERT_IMP(a_rel_refresh_ok, i_clk, i_rst_n,
                    o_done && o_status == ST_EMPTY, o_released_count == 5'd0)
endmodule

>>> test/tb_timed_task_scheduler.sv
// Testbench for the timed task scheduler: random and directed commands checked against a predictor
module tb_timed_task_scheduler import tts_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status     status;
        logic [3:0]  tag;
        logic [31:0] handle;
        logic [31:0] interval;
        logic [4:0]  released;
    } t_outcome;

    class sched_scoreboard;
        bit          slot_used[TimerSlots];
        bit          slot_per[TimerSlots];
        logic [31:0] slot_hnd[TimerSlots];
        logic [31:0] slot_ivl[TimerSlots];
        logic [31:0] slot_start[TimerSlots];
        logic [3:0]  rq_tag[$];
        logic [31:0] rq_hnd[$];
        logic [31:0] rq_ivl[$];
        t_outcome    pending[$];
        int          errors;
        int          checked;

        function bit enqueue(logic [3:0] tg, logic [31:0] h, logic [31:0] iv);
            if (rq_tag.size() >= ReadyDepth) return 0;
            rq_tag = {rq_tag, tg};
            rq_hnd = {rq_hnd, h};
            rq_ivl = {rq_ivl, iv};
            return 1;
        endfunction

        function void note_command(t_item it);
            t_outcome r;
            int s;
            r.status = ST_OK;
            r.tag = it.tag;
            r.handle = '0;
            r.interval = '0;
            r.released = '0;
            case (it.cmd)
                CMD_PUSH: if (!enqueue(it.tag, it.handle, '0)) r.status = ST_OVF;
                CMD_ADD_PER, CMD_ADD_DLY: begin
                    if (slot_used[it.tag]) begin
                        r.status = ST_BUSY;
                    end else begin
                        slot_used[it.tag] = 1;
                        slot_per[it.tag] = (it.cmd == CMD_ADD_PER);
                        slot_hnd[it.tag] = it.handle;
                        slot_ivl[it.tag] = it.interval;
                        slot_start[it.tag] = it.now;
                        if (it.cmd == CMD_ADD_PER && !enqueue(it.tag, it.handle, it.interval))
                            r.status = ST_OVF;
                    end
                end
                CMD_REMOVE: begin
                    slot_used[it.tag] = 0;
                    slot_per[it.tag] = 0;
                    foreach (rq_tag[i]) if (rq_tag[i] == it.tag) begin
                        rq_tag.delete(i);
                        rq_hnd.delete(i);
                        rq_ivl.delete(i);
                        break;
                    end
                end
                CMD_CLEAR: begin
                    slot_used = '{default: 0};
                    slot_per = '{default: 0};
                    rq_tag.delete();
                    rq_hnd.delete();
                    rq_ivl.delete();
                end
                CMD_POP: begin
                    if (rq_tag.size() == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.tag = rq_tag.pop_front();
                        r.handle = rq_hnd.pop_front();
                        r.interval = rq_ivl.pop_front();
                    end
                end
                CMD_REFRESH: begin
                    for (int pass = 0; pass < 2; pass++) begin
                        for (s = 0; s < TimerSlots; s++) begin
                            if (!slot_used[s] || slot_per[s] != (pass == 0)) continue;
                            if (32'(it.now - slot_start[s]) < slot_ivl[s]) continue;
                            if (enqueue(4'(s), slot_hnd[s], slot_ivl[s])) begin
                                if (r.released < 31) r.released++;
                            end else begin
                                r.status = ST_OVF;
                            end
                            if (pass == 0) begin
                                slot_start[s] = it.now;
                            end else begin
                                slot_used[s] = 0;
                            end
                        end
                    end
                end
                default: ;
            endcase
            pending = {pending, r};
        endfunction

        function void check_result(t_outcome got);
            t_outcome e;
            checked++;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.tag !== e.tag) begin
                $error("out_tag exp %0d got %0d", e.tag, got.tag); errors++;
            end
            if (got.handle !== e.handle) begin
                $error("out_handle exp %h got %h", e.handle, got.handle); errors++;
            end
            if (got.interval !== e.interval) begin
                $error("out_interval exp %h got %h", e.interval, got.interval); errors++;
            end
            if (got.released !== e.released) begin
                $error("released_count exp %0d got %0d", e.released, got.released);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [2:0]  i_cmd = '0;
    logic [3:0]  i_task_tag = '0;
    logic [31:0] i_handle = '0;
    logic [31:0] i_interval_ms = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [3:0]  o_out_tag;
    logic [31:0] o_out_handle;
    logic [31:0] o_out_interval;
    logic [4:0]  o_released_count;

    sched_scoreboard sb = new();
    logic [31:0] clock_ms = 0;
    int  idle_pct = 36;
    int  stall_cycles = 0;
    int  cmd_hist[8];

    timed_task_scheduler dut (.*);

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n && o_done) begin
            got.status = t_status'(o_status);
            got.tag = o_out_tag;
            got.handle = o_out_handle;
            got.interval = o_out_interval;
            got.released = o_released_count;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 2000) begin
            $display("timed_task_scheduler regression: fail");
            $finish;
        end
    end

    task automatic issue(t_cmd c, logic [3:0] tg, logic [31:0] h, logic [31:0] iv,
                         logic [31:0] nw);
        t_item it;
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        it.cmd = c; it.tag = tg; it.handle = h; it.interval = iv; it.now = nw;
        start <= 1;
        i_cmd <= c; i_task_tag <= tg; i_handle <= h; i_interval_ms <= iv; i_now_ms <= nw;
        do @(posedge i_clk); while (busy);
        sb.note_command(it);
        cmd_hist[c]++;
    endtask

    task automatic drain();
        start <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_command();
        t_cmd c;
        logic [31:0] iv;
        int p = $urandom_range(99);
        clock_ms += $urandom_range(40);
        if (p < 15) c = CMD_PUSH;
        else if (p < 30) c = CMD_ADD_PER;
        else if (p < 45) c = CMD_ADD_DLY;
        else if (p < 55) c = CMD_REMOVE;
        else if (p < 57) c = CMD_CLEAR;
        else if (p < 77) c = CMD_POP;
        else if (p < 97) c = CMD_REFRESH;
        else c = CMD_NONE;
        iv = ($urandom_range(9) == 0) ? $urandom : $urandom_range(100);
        issue(c, 4'($urandom), $urandom, iv,
              ($urandom_range(19) == 0) ? $urandom : clock_ms);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        idle_pct = 0;
        issue(CMD_POP, 4'd3, '1, '1, '1);
        issue(CMD_PUSH, 4'd15, '1, '1, 0);
        issue(CMD_ADD_PER, 4'd0, 32'h0, 32'd0, '1);
        issue(CMD_ADD_PER, 4'd0, 32'h1, 32'd5, 0);
        issue(CMD_ADD_DLY, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
        issue(CMD_ADD_DLY, 4'd5, 32'hA5A5_5A5A, 32'd10, 32'hFFFF_FFFA);
        issue(CMD_REFRESH, 4'd0, 0, 0, 32'd4);
        issue(CMD_REFRESH, 4'd0, 0, 0, 32'hFFFF_FFEF);
        issue(CMD_PUSH, 4'd15, 32'h1234, 0, 0);
        issue(CMD_REMOVE, 4'd15, 0, 0, 0);
        issue(CMD_POP, 4'd0, 0, 0, 0);
        issue(CMD_NONE, 4'd9, '1, '1, '1);
        for (int k = 0; k < 18; k++) issue(CMD_PUSH, 4'(k), $urandom, 0, 0);
        issue(CMD_ADD_PER, 4'd7, 32'h77, 0, 0);
        issue(CMD_REFRESH, 4'd0, 0, 0, 0);
        issue(CMD_CLEAR, 4'd0, 0, 0, 0);
        drain();
        idle_pct = 36;
        for (int n = 0; n < 1150; n++) begin
            idle_pct = (n >= 400 && n < 600) ? 0 : 36;
            if (n == 800) drain();
            random_command();
        end
        drain();
        $display("covered %0d results; push %0d add %0d/%0d remove %0d clear %0d pop %0d",
                 sb.checked, cmd_hist[CMD_PUSH], cmd_hist[CMD_ADD_PER],
                 cmd_hist[CMD_ADD_DLY], cmd_hist[CMD_REMOVE], cmd_hist[CMD_CLEAR],
                 cmd_hist[CMD_POP]);
        $display("refresh %0d, unused %0d", cmd_hist[CMD_REFRESH], cmd_hist[CMD_NONE]);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("timed_task_scheduler regression: pass");
        end else begin
            $display("timed_task_scheduler regression: fail");
        end
        $finish;
    end
endmodule

>>> timed_task_scheduler.f
+incdir+sv
sv/tts_pkg.sv
sv/tts_front.sv
sv/tts_back.sv
sv/timed_task_scheduler.sv
test/tb_timed_task_scheduler.sv
